>>> rtl/rptke_pkg.sv
`default_nettype none

package rptke_pkg;

    localparam int MAX_TAG     = 7;
    localparam int MAX_SEQ_LEN = 65536;

    localparam int CODE_W  = 5;
    localparam int KEY_W   = CODE_W * MAX_TAG;
    localparam int RES_W   = 7;
    localparam int ID_W    = 20;
    localparam int POS_W   = 16;
    localparam int LEN_W   = 3;
    localparam int FILL_W  = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 3;

    localparam logic [RES_W-1:0]  CHAR_I      = 7'd73;
    localparam logic [RES_W-1:0]  CHAR_L      = 7'd76;
    localparam logic [POS_W-1:0]  INDEX_LIMIT = POS_W'(MAX_SEQ_LEN - 1);
    localparam logic [FILL_W-1:0] FILL_MAX    = FILL_W'(MAX_TAG);
    localparam logic [LEN_W-1:0]  LEN_MIN     = 3'd2;
    localparam logic [LEN_W-1:0]  LEN_MAX     = LEN_W'(MAX_TAG - 1);
    localparam logic [LEN_W-1:0]  TAG_LEN_RST = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAG_LEN  = 1'b0,
        CFG_DUAL_LEN = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic              short_vld;
        logic              long_vld;
        logic [KEY_W-1:0]  key_short;
        logic [KEY_W-1:0]  key_long;
        logic [ID_W-1:0]   seq_id;
        logic [POS_W-1:0]  pos_short;
        logic [POS_W-1:0]  pos_long;
    } t_job;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  seq_id;
        logic [POS_W-1:0] position;
        logic             long_tag;
        logic             last;
    } t_result;

    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] n;
        n = len;
        if (n < LEN_MIN) n = LEN_MIN;
        if (n > LEN_MAX) n = LEN_MAX;
        return n;
    endfunction

    function automatic logic [KEY_W-1:0] key_mask(input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_TAG; i++) begin
            if (LEN_W'(i) < len) begin
                m[i*CODE_W +: CODE_W] = '1;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rptke_in_if.sv
`default_nettype none

interface rptke_in_if
    import rptke_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [RES_W-1:0]  residue;
    logic              first;
    logic [ID_W-1:0]   protein_id;

    modport source (output valid, output residue, output first, output protein_id,
                    input ready);
    modport sink   (input valid, input residue, input first, input protein_id,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/rptke_out_if.sv
`default_nettype none

interface rptke_out_if
    import rptke_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  key;
    logic [ID_W-1:0]   seq_id;
    logic [POS_W-1:0]  position;
    logic              long_tag;
    logic              last;

    modport source (output valid, output key, output seq_id, output position,
                    output long_tag, output last, input ready);
    modport sink   (input valid, input key, input seq_id, input position,
                    input long_tag, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/rptke_encode.sv
`default_nettype none

module rptke_encode
    import rptke_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire logic [RES_W-1:0]  i_residue,
    input  wire logic              i_first,
    input  wire logic [ID_W-1:0]   i_protein_id,
    input  wire logic [LEN_W-1:0]  i_tag_len,
    input  wire logic              i_dual_len,
    output t_job                   o_job
);

    logic [KEY_W-1:0]  r_window, n_window;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [POS_W-1:0]  r_index, n_index;

    logic [RES_W-1:0]  letter;
    logic [CODE_W-1:0] code;
    logic [KEY_W-1:0]  base_window;
    logic [LEN_W-1:0]  len;
    logic [LEN_W:0]    len_long;
    logic [POS_W-1:0]  back_short;
    logic [POS_W-1:0]  back_long;
    logic              sat;

    always_comb begin
        letter = (i_residue == CHAR_I) ? CHAR_L : i_residue;
        code   = letter[CODE_W-1:0];

        if (i_first) begin
            n_index     = '0;
            n_fill      = FILL_W'(1);
            base_window = '0;
        end else begin
            base_window = r_window;
            n_index     = (r_fill != '0 && r_index < INDEX_LIMIT) ?
                          r_index + POS_W'(1) : r_index;
            n_fill      = (r_fill < FILL_MAX) ? r_fill + FILL_W'(1) : r_fill;
        end
        n_window = {base_window[KEY_W-CODE_W-1:0], code};

        len      = eff_len(i_tag_len);
        len_long = {1'b0, len} + (LEN_W+1)'(1);
        sat      = (n_index >= INDEX_LIMIT);
        back_short = POS_W'(len) - POS_W'(1);
        back_long  = POS_W'(len);

        o_job.short_vld = (n_fill >= len);
        o_job.long_vld  = i_dual_len && ({1'b0, n_fill} >= len_long);
        o_job.key_short = n_window & key_mask(len);
        o_job.key_long  = n_window & key_mask(len_long[LEN_W-1:0]);
        o_job.seq_id    = i_protein_id;
        o_job.pos_short = sat ? INDEX_LIMIT : n_index - back_short;
        o_job.pos_long  = sat ? INDEX_LIMIT : n_index - back_long;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_fill   <= '0;
            r_index  <= '0;
        end else if (i_take) begin
            r_window <= n_window;
            r_fill   <= n_fill;
            r_index  <= n_index;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rptke_emit.sv
`default_nettype none

module rptke_emit
    import rptke_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_take,
    input  wire t_job  i_job,
    input  wire logic  i_out_ready,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_result    o_result
);

    logic    r_out_vld;
    logic    r_pend_vld;
    t_result r_out;
    t_result r_pend;
    logic    slot_free;
    t_result res_short;
    t_result res_long;

    always_comb begin
        slot_free  = !r_out_vld || i_out_ready;
        o_in_ready = slot_free && !r_pend_vld;

        res_short.key      = i_job.key_short;
        res_short.seq_id   = i_job.seq_id;
        res_short.position = i_job.pos_short;
        res_short.long_tag = 1'b0;
        res_short.last     = !i_job.long_vld;

        res_long.key       = i_job.key_long;
        res_long.seq_id    = i_job.seq_id;
        res_long.position  = i_job.pos_long;
        res_long.long_tag  = 1'b1;
        res_long.last      = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else if (i_take) begin
            r_out_vld  <= i_job.short_vld || i_job.long_vld;
            r_pend_vld <= i_job.short_vld && i_job.long_vld;
        end else if (r_pend_vld && slot_free) begin
            r_out_vld  <= 1'b1;
            r_pend_vld <= 1'b0;
        end else if (slot_free) begin
            r_out_vld  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_out  <= i_job.short_vld ? res_short : res_long;
            r_pend <= res_long;
        end else if (r_pend_vld && slot_free) begin
            r_out  <= r_pend;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_result    = r_out;

endmodule

`default_nettype wire

>>> rtl/rolling_peptide_tag_key_encoder.sv
// Rolling peptide tag key encoder.
// Input channel i_in: one amino-acid letter per item with a first-of-protein
// flag and the protein id. Output channel o_out: tag keys (5 bits per letter,
// oldest letter most significant) with protein id, start position, long_tag
// and last. Each letter yields zero, one or two results; last marks the final
// result of a letter.
// Latency: a letter's first result is presented the cycle after it is accepted.
// Throughput: one letter per cycle while each letter yields at most one
// result and the receiver does not stall; a letter with a short and a long
// key holds off the next letter until the long key leaves the holding slot.
// The output register plus a one-entry holding slot for the long key decouple
// the sides: a new letter is taken while the previous result is being taken.
// If the receiver stalls, the presented result holds and i_in.ready drops
// once the output register cannot be freed.
// Configuration (tag_len at index 0, dual_len at index 1) is written through
// i_cfg_we/idx/wdata by the user only while the block is idle (not enforced).
// Synchronous reset clears the window, fill count, letter index and both
// output slots, and sets tag_len = 4, dual_len = 0.
`default_nettype none

module rolling_peptide_tag_key_encoder
    import rptke_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_wdata,
    rptke_in_if.sink                  i_in,
    rptke_out_if.source               o_out
);

    logic [LEN_W-1:0] r_tag_len;
    logic             r_dual_len;
    logic             take;
    logic             in_ready;
    t_job             job;
    t_result          result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_len  <= TAG_LEN_RST;
            r_dual_len <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TAG_LEN:  r_tag_len  <= i_cfg_wdata[LEN_W-1:0];
                CFG_DUAL_LEN: r_dual_len <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign take       = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    rptke_encode u_encode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_residue    (i_in.residue),
        .i_first      (i_in.first),
        .i_protein_id (i_in.protein_id),
        .i_tag_len    (r_tag_len),
        .i_dual_len   (r_dual_len),
        .o_job        (job)
    );

    rptke_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_job       (job),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (o_out.valid),
        .o_result    (result)
    );

    assign o_out.key      = result.key;
    assign o_out.seq_id   = result.seq_id;
    assign o_out.position = result.position;
    assign o_out.long_tag = result.long_tag;
    assign o_out.last     = result.last;

endmodule

`default_nettype wire

>>> rtl/rptke_checker.sv
`default_nettype none

module rptke_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_long_tag,
    input wire logic i_out_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output item dropped while stalled");

    a_long_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_long_tag |-> i_out_last)
        else $error("long tag not marked last");

    a_long_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid && i_out_long_tag)
        else $error("long tag does not follow short tag");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input taken while long tag pending");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind rolling_peptide_tag_key_encoder rptke_checker u_rptke_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_long_tag (o_out.long_tag),
    .i_out_last     (o_out.last)
);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import rptke_pkg::*;

    localparam logic [ID_W-1:0] ID_TOP = '1;

    class tag_key_predictor;
        logic [KEY_W-1:0]  window;
        logic [FILL_W-1:0] fill;
        logic [POS_W-1:0]  index;
        logic [LEN_W-1:0]  tag_len;
        logic              dual_len;
        t_result           pending_keys[$];
        int                faults;
        int                letters;
        int                keys;
        int                long_keys;

        function new();
            window    = '0;
            fill      = '0;
            index     = '0;
            tag_len   = TAG_LEN_RST;
            dual_len  = 1'b0;
            faults    = 0;
            letters   = 0;
            keys      = 0;
            long_keys = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DAT_W-1:0] val);
            if (idx == CFG_TAG_LEN) begin
                tag_len = val[LEN_W-1:0];
            end else begin
                dual_len = val[0];
            end
        endfunction

        function t_result tag_at(int n, logic [ID_W-1:0] id, logic is_long);
            logic [63:0] mask;
            t_result     r;
            mask       = (64'd1 << (CODE_W * n)) - 64'd1;
            r.key      = window & mask[KEY_W-1:0];
            r.seq_id   = id;
            r.position = (index >= INDEX_LIMIT) ? INDEX_LIMIT : POS_W'(index - POS_W'(n - 1));
            r.long_tag = is_long;
            r.last     = 1'b0;
            return r;
        endfunction

        function void note_letter(logic [RES_W-1:0] res, logic first, logic [ID_W-1:0] id);
            logic [RES_W-1:0] ch;
            logic [CODE_W-1:0] code;
            int               n;
            int               cnt;
            t_result          got[2];
            n   = int'((tag_len < LEN_MIN) ? LEN_MIN : (tag_len > LEN_MAX) ? LEN_MAX : tag_len);
            cnt = 0;
            letters++;
            if (first) begin
                window = '0;
                fill   = '0;
                index  = '0;
            end else if (fill != 0 && index < INDEX_LIMIT) begin
                index++;
            end
            ch = (res == CHAR_I) ? CHAR_L : res;
            // letter - 'A' + 1, modulo 32
            code   = CODE_W'(ch - 7'd64);
            window = {window[KEY_W-CODE_W-1:0], code};
            if (fill < FILL_MAX) fill++;
            if (int'(fill) >= n) begin
                got[cnt] = tag_at(n, id, 1'b0);
                cnt++;
            end
            if (dual_len && int'(fill) >= n + 1) begin
                got[cnt] = tag_at(n + 1, id, 1'b1);
                cnt++;
            end
            if (cnt > 0) got[cnt-1].last = 1'b1;
            for (int k = 0; k < cnt; k++) pending_keys = {pending_keys, got[k]};
        endfunction

        function void flag(string field, logic [63:0] e, logic [63:0] g);
            if (e !== g) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, e, g);
                faults++;
            end
        endfunction

        function void check_key(t_result got);
            t_result e;
            if (pending_keys.size() == 0) begin
                $display("%0t: unexpected key, expected none, actual key %0h id %0h pos %0d",
                         $time, got.key, got.seq_id, got.position);
                faults++;
                return;
            end
            e = pending_keys.pop_front();
            keys++;
            if (e.long_tag) long_keys++;
            flag("key", 64'(e.key), 64'(got.key));
            flag("seq_id", 64'(e.seq_id), 64'(got.seq_id));
            flag("position", 64'(e.position), 64'(got.position));
            flag("long_tag", 64'(e.long_tag), 64'(got.long_tag));
            flag("last", 64'(e.last), 64'(got.last));
        endfunction

        function void report_leftover();
            if (pending_keys.size() != 0) begin
                $display("%0t: %0d keys never arrived, expected key %0h, actual none",
                         $time, pending_keys.size(), pending_keys[0].key);
                faults++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_wdata;

    rptke_in_if  in_ch ();
    rptke_out_if out_ch ();

    rolling_peptide_tag_key_encoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    tag_key_predictor tag_keys = new();
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int recv_hold_req  = 0;
    int hold_left      = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("rolling_peptide_tag_key_encoder test failed");
        $finish;
    end

    // receiver: random stalls plus a long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (recv_hold_req != 0) begin
                hold_left     = recv_hold_req;
                recv_hold_req = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                tag_keys.note_letter(in_ch.residue, in_ch.first, in_ch.protein_id);
            end
            if (out_ch.valid && out_ch.ready) begin
                tag_keys.check_key('{key: out_ch.key, seq_id: out_ch.seq_id,
                                     position: out_ch.position, long_tag: out_ch.long_tag,
                                     last: out_ch.last});
            end
        end
    end

    task automatic push_letter(input logic [RES_W-1:0] res, input logic first,
                               input logic [ID_W-1:0] id);
        while ($urandom_range(99) < send_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.residue    <= res;
        in_ch.first      <= first;
        in_ch.protein_id <= id;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic await_drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tag_keys.pending_keys.size() != 0) @(posedge i_clk);
        // letters that make no key may still be in flight
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DAT_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        tag_keys.write_reg(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_phase(input logic [CFG_DAT_W-1:0] tlen, input logic dual,
                             input int gap, input int stall);
        await_drain();
        write_reg(CFG_TAG_LEN, tlen);
        write_reg(CFG_DUAL_LEN, {{(CFG_DAT_W-1){1'b0}}, dual});
        send_gap_pct   = gap;
        recv_stall_pct = stall;
    endtask

    function automatic logic [RES_W-1:0] pick_residue();
        int r;
        r = $urandom_range(99);
        if (r < 5) return CHAR_I;
        if (r < 11) return RES_W'($urandom_range(127));
        return RES_W'($urandom_range(90, 65));
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(9))
            0: return '0;
            1: return ID_TOP;
            default: return ID_W'($urandom);
        endcase
    endfunction

    // proteins of random length; a few miss their first flag or change id midway
    task automatic run_proteins(input int n_items, input int pause_at);
        int              sent;
        int              plen;
        logic [ID_W-1:0] id;
        logic            first;
        sent = 0;
        while (sent < n_items) begin
            plen = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : $urandom_range(40, 4);
            id   = pick_id();
            for (int k = 0; k < plen && sent < n_items; k++) begin
                first = (k == 0) ? ($urandom_range(19) != 0) : ($urandom_range(49) == 0);
                if (k > 0 && $urandom_range(29) == 0) id = pick_id();
                if (sent == pause_at) await_drain();
                push_letter(pick_residue(), first, id);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_TAG_LEN;
        i_cfg_wdata      = '0;
        in_ch.valid      = 1'b0;
        in_ch.residue    = '0;
        in_ch.first      = 1'b0;
        in_ch.protein_id = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, no first flag at the start
        push_letter(RES_W'("A"), 1'b0, '0);
        push_letter(RES_W'("Z"), 1'b0, '0);
        push_letter(CHAR_I, 1'b0, '0);
        push_letter(CHAR_L, 1'b0, '0);
        push_letter(RES_W'("M"), 1'b1, ID_TOP);
        push_letter(7'h00, 1'b0, ID_TOP);
        push_letter(7'h7F, 1'b0, ID_TOP);
        push_letter(RES_W'("Y"), 1'b0, ID_TOP);
        push_letter(CHAR_I, 1'b0, ID_TOP);
        push_letter(RES_W'("C"), 1'b0, 20'h5A5A5);

        set_phase(3'd6, 1'b1, 0, 0);
        push_letter(RES_W'("W"), 1'b1, 20'h00001);
        push_letter(RES_W'("V"), 1'b0, 20'h00001);
        push_letter(CHAR_I, 1'b0, 20'h00001);
        push_letter(RES_W'("K"), 1'b0, 20'h00001);
        push_letter(RES_W'("E"), 1'b0, 20'h00001);
        push_letter(RES_W'("R"), 1'b0, 20'h00001);
        push_letter(RES_W'("D"), 1'b0, 20'h00001);
        push_letter(RES_W'("Q"), 1'b0, 20'h00001);

        set_phase(3'd2, 1'b1, 0, 0);
        push_letter(RES_W'("A"), 1'b1, 20'hA5A5A);
        push_letter(RES_W'("B"), 1'b0, 20'hA5A5A);
        push_letter(RES_W'("Z"), 1'b0, 20'hA5A5A);

        set_phase(3'd2, 1'b0, 0, 0);
        run_proteins(300, -1);
        set_phase(3'd6, 1'b1, 65, 0);
        run_proteins(300, 150);
        set_phase(3'd4, 1'b1, 0, 65);
        run_proteins(300, -1);
        set_phase(3'd3, 1'b0, 10, 10);
        run_proteins(300, -1);
        set_phase(3'd7, 1'b1, 0, 0);
        recv_hold_req = 400;
        run_proteins(250, -1);
        set_phase(3'd0, 1'b1, 65, 65);
        run_proteins(120, -1);
        set_phase(3'd1, 1'b0, 10, 10);
        run_proteins(130, -1);
        set_phase(3'd5, 1'b1, 10, 10);
        run_proteins(250, -1);

        await_drain();
        repeat (10) @(posedge i_clk);
        tag_keys.report_leftover();
        $display("Covered %0d letters and %0d keys (%0d long)",
                 tag_keys.letters, tag_keys.keys, tag_keys.long_keys);
        $display("over tag lengths 0 to 7, single and dual keys, idle and stall mixes.");
        if (tag_keys.faults == 0) begin
            $display("rolling_peptide_tag_key_encoder test passed");
        end else begin
            $display("rolling_peptide_tag_key_encoder test failed");
        end
        $finish;
    end

endmodule
